/* rtl/rfe_pkg.sv */
// Shared types, constants and fixed-point helpers for the frame size estimator.
// Used by rfe_arith and rfid_frame_size_estimator; depends on nothing else.
package rfe_pkg;

    localparam int MAX_FRAME      = 1024;
    localparam int MAX_ITERATIONS = 16;
    localparam int FRACTION_BITS  = 28;

    localparam int FRAME_W    = $clog2(MAX_FRAME + 1);
    localparam int ITER_W     = $clog2(MAX_ITERATIONS + 1);
    localparam int ITER_OUT_W = 5;
    localparam int REPLY_W    = 8;
    localparam int THRESH_W   = 29;
    localparam int GAMMA_W    = 31;
    localparam int GAMMA_OUT_W = 32;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    localparam int DATA_W     = 64;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int HALF_W     = DATA_W / 2;
    localparam int MUL_STEPS  = 4;
    localparam int DIV_STEPS  = DATA_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // exp series length and exponent range of the integer part
    localparam int SERIES_TERMS = 30;
    localparam int K_W          = $clog2(SERIES_TERMS + 1);
    localparam int EXP_INT_W    = 6;

    localparam logic [DATA_W-1:0] FX_ONE  = 64'd1 << FRACTION_BITS;
    localparam logic [DATA_W-1:0] FX_TWO  = 64'd2 << FRACTION_BITS;
    localparam logic [DATA_W-1:0] FX_MAX  = '1;
    localparam logic [DATA_W-1:0] FX_FRAC_MASK = FX_ONE - 64'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAMMA = 2'd2;

    localparam logic [FRAME_W-1:0]   INIT_FRAME_RESET = 11'd64;
    localparam logic [THRESH_W-1:0]  THRESHOLD_RESET  = 29'd268435;
    localparam logic [GAMMA_W-1:0]   INIT_GAMMA_RESET = 31'd536870912;

    typedef enum logic [1:0] {
        ARITH_MUL = 2'b01,
        ARITH_DIV = 2'b10
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    // saturating 64-bit add
    function automatic logic [DATA_W-1:0] fx_sat_add(input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? FX_MAX : s[DATA_W-1:0];
    endfunction

    // fixed-point product from a full 128-bit product, saturated
    function automatic logic [DATA_W-1:0] fx_mul_res(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] sh;
        sh = p >> FRACTION_BITS;
        return ((p >> (DATA_W + FRACTION_BITS)) != '0) ? FX_MAX : sh[DATA_W-1:0];
    endfunction

    // integer product from a full 128-bit product, saturated
    function automatic logic [DATA_W-1:0] int_mul_res(input logic [PROD_W-1:0] p);
        return (p[PROD_W-1:DATA_W] != '0) ? FX_MAX : p[DATA_W-1:0];
    endfunction

    // limit a slot count to 1..MAX_FRAME
    function automatic logic [FRAME_W-1:0] clamp_frame(input logic [DATA_W-1:0] v);
        logic [FRAME_W-1:0] r;
        if (v == '0)
        begin
            r = FRAME_W'(1);
        end
        else if (v > DATA_W'(MAX_FRAME))
        begin
            r = FRAME_W'(MAX_FRAME);
        end
        else
        begin
            r = v[FRAME_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/rfe_arith.sv */
// Shared arithmetic unit: 64x64 multiply from four 32x32 partial products,
// and 128/64 restoring division one quotient bit per cycle. Uses rfe_pkg.
module rfe_arith (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rfe_pkg::arith_req_t        req,
    input  logic [rfe_pkg::DATA_W-1:0] opa,
    input  logic [rfe_pkg::DATA_W-1:0] opb,
    input  logic [rfe_pkg::DATA_W-1:0] div_hi,
    output logic                       done,
    output logic [rfe_pkg::PROD_W-1:0] prod,
    output logic [rfe_pkg::DATA_W-1:0] quot
);
    import rfe_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    arith_op_t           op_reg, op_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]   a_reg, a_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic [DATA_W-1:0]   pp_reg, pp_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;

    logic [HALF_W-1:0]   mul_x, mul_y;
    logic [PROD_W-1:0]   pp_shifted;
    logic [DATA_W:0]     trial;
    logic                take;

    // select partial product operands and alignment
    always_comb
    begin
        mul_x = cnt_reg[1] ? a_reg[DATA_W-1:HALF_W] : a_reg[HALF_W-1:0];
        mul_y = cnt_reg[0] ? b_reg[DATA_W-1:HALF_W] : b_reg[HALF_W-1:0];
        case (cnt_reg)
            STEP_W'(1):              pp_shifted = {{DATA_W{1'b0}}, pp_reg};
            STEP_W'(2), STEP_W'(3):  pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default:                 pp_shifted = {pp_reg, {DATA_W{1'b0}}};
        endcase
        trial = {rem_reg, a_reg[DATA_W-1]};
        take  = trial >= {1'b0, b_reg};
    end

    // advance the running operation
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                cnt_next  = '0;
                a_next    = opa;
                b_next    = opb;
                acc_next  = '0;
                rem_next  = div_hi;
            end
        end
        else if (op_reg == ARITH_MUL)
        begin
            if (cnt_reg < STEP_W'(MUL_STEPS))
            begin
                pp_next = mul_x * mul_y;
            end
            if (cnt_reg != '0)
            begin
                acc_next = acc_reg + pp_shifted;
            end
            if (cnt_reg == STEP_W'(MUL_STEPS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            // one restoring step: quotient bits shift into the dividend register
            rem_next = take ? 64'(trial - {1'b0, b_reg}) : trial[DATA_W-1:0];
            a_next   = {a_reg[DATA_W-2:0], take};
            if (cnt_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ARITH_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign quot = a_reg;

endmodule

/* rtl/rfid_frame_size_estimator.sv */
// Top level of the framed-slotted ALOHA frame size estimator.
// Depends on rfe_pkg and rfe_arith.
//
// Usage: each input word is one slot (reply count and a start-of-round flag).
// Slots are counted as empty, single or collided until the frame size is
// reached. The closing slot produces one output word and, if the frame had
// collisions, first launches the tag estimate; other slots produce none.
// A slot that does not close a frame leaves the block idle. A closing
// slot with no collisions skips the estimate and goes straight to the
// output word. With collisions the shared unit sets the pace, with its
// 64-step divisions. One recurrence iteration runs 30 series terms of a
// multiply and a division by the term index, three multiplies, two divisions
// and an update, plus one multiply per whole unit of x for the e^-1 powers;
// an x of 64 or more skips the series. Up to 16 iterations run, then a
// multiply forms the next frame size and the output word is loaded. The first
// estimate after reset also forms e^-1, which is then kept. in_stall stays
// high for the whole estimate.
// Reset loads the register defaults, a frame size of 64 and clears counters.
// The result sits in an output register; if out_stall holds it, slot counting
// goes on, and a later closing slot waits until that word is taken.
module rfid_frame_size_estimator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rfe_pkg::REPLY_W-1:0]    replies,
    input  logic                           start_round,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rfe_pkg::FRAME_W-1:0]    next_frame_size,
    output logic [rfe_pkg::FRAME_W-1:0]    success_slots,
    output logic [rfe_pkg::FRAME_W-1:0]    collision_slots,
    output logic [rfe_pkg::FRAME_W-1:0]    empty_slots,
    output logic [rfe_pkg::GAMMA_OUT_W-1:0] gamma_estimate,
    output logic [rfe_pkg::ITER_OUT_W-1:0] iterations_used,
    output logic                           iteration_limit_hit,
    output logic                           round_finished
);
    import rfe_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_DMUL = 12'b0000_0000_0010,
        ST_XDIV = 12'b0000_0000_0100,
        ST_TMUL = 12'b0000_0000_1000,
        ST_TDIV = 12'b0000_0001_0000,
        ST_EPOW = 12'b0000_0010_0000,
        ST_PMUL = 12'b0000_0100_0000,
        ST_NMUL = 12'b0000_1000_0000,
        ST_GDIV = 12'b0001_0000_0000,
        ST_UPD  = 12'b0010_0000_0000,
        ST_CMUL = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } state_t;

    // configuration
    logic [FRAME_W-1:0]  init_frame_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [GAMMA_W-1:0]  init_gamma_reg;

    // control and counters
    state_t              state_reg, state_next;
    logic                issued_reg, issued_next;
    logic [FRAME_W-1:0]  cur_frame_reg, cur_frame_next;
    logic [FRAME_W-1:0]  slot_reg, slot_next;
    logic [FRAME_W-1:0]  succ_reg, succ_next;
    logic [FRAME_W-1:0]  coll_reg, coll_next;
    logic [FRAME_W-1:0]  empty_reg, empty_next;
    logic [ITER_W-1:0]   iters_reg, iters_next;
    logic                limit_reg, limit_next;
    logic                e1_ok_reg, e1_ok_next;
    logic                ser_e1_reg, ser_e1_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [EXP_INT_W-1:0] n_reg, n_next;
    logic                out_valid_reg, out_valid_next;

    // datapath
    logic [DATA_W-1:0]   gamma_reg, gamma_next;
    logic [DATA_W-1:0]   x_reg, x_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   term_reg, term_next;
    logic [DATA_W-1:0]   e_reg, e_next;
    logic [DATA_W-1:0]   e1_reg, e1_next;
    logic [DATA_W-1:0]   p_reg, p_next;
    logic [DATA_W-1:0]   tmp_reg, tmp_next;
    logic [FRAME_W-1:0]  next_size_reg, next_size_next;

    // output word
    logic [FRAME_W-1:0]     o_next_reg, o_succ_reg, o_coll_reg, o_empty_reg;
    logic [GAMMA_OUT_W-1:0] o_gamma_reg;
    logic [ITER_OUT_W-1:0]  o_iters_reg;
    logic                   o_limit_reg, o_fin_reg;
    logic                   out_load;

    // shared unit
    arith_req_t          req;
    logic [DATA_W-1:0]   opa, opb, div_hi;
    logic                arith_done;
    logic [PROD_W-1:0]   prod;
    logic [DATA_W-1:0]   quot;

    // slot classification
    logic [FRAME_W-1:0]  frame_eff, slot_inc, succ_inc, coll_inc, empty_inc;
    logic                op_state, gdiv_sat;
    logic [DATA_W-1:0]   series_v, acc_upd, diff, c_val, p_val;
    logic [ITER_W-1:0]   iters_inc;
    logic [PROD_W-1:0]   num_shift;

    // classify the slot against the frame in force
    always_comb
    begin
        frame_eff = start_round ? clamp_frame(DATA_W'(init_frame_reg)) : cur_frame_reg;
        slot_inc  = (start_round ? '0 : slot_reg) + 1'b1;
        succ_inc  = start_round ? '0 : succ_reg;
        coll_inc  = start_round ? '0 : coll_reg;
        empty_inc = start_round ? '0 : empty_reg;
        if (replies == '0)
        begin
            empty_inc = empty_inc + 1'b1;
        end
        else if (replies == REPLY_W'(1))
        begin
            succ_inc = succ_inc + 1'b1;
        end
        else
        begin
            coll_inc = coll_inc + 1'b1;
        end
    end

    // select the shared unit operation for each state
    always_comb
    begin
        series_v  = ser_e1_reg ? FX_ONE : (x_reg & FX_FRAC_MASK);
        num_shift = {{DATA_W{1'b0}}, tmp_reg} << FRACTION_BITS;
        gdiv_sat  = num_shift[PROD_W-1:DATA_W] >= (FX_ONE - p_reg);
        op_state  = 1'b1;
        req.op    = ARITH_MUL;
        opa       = gamma_reg;
        opb       = DATA_W'(coll_reg);
        div_hi    = '0;
        case (state_reg)
            ST_DMUL, ST_CMUL:
            begin
                opa = gamma_reg;
                opb = DATA_W'(coll_reg);
            end
            ST_XDIV:
            begin
                req.op = ARITH_DIV;
                opa    = x_reg;
                opb    = DATA_W'(cur_frame_reg);
            end
            ST_TMUL:
            begin
                opa = term_reg;
                opb = series_v;
            end
            ST_TDIV:
            begin
                req.op = ARITH_DIV;
                opa    = term_reg;
                opb    = DATA_W'(k_reg);
            end
            ST_EPOW:
            begin
                opa = e_reg;
                opb = e1_reg;
            end
            ST_PMUL:
            begin
                opa = fx_sat_add(FX_ONE, x_reg);
                opb = e_reg;
            end
            ST_NMUL:
            begin
                opa = x_reg;
                opb = FX_ONE - e_reg;
            end
            ST_GDIV:
            begin
                req.op = ARITH_DIV;
                opa    = num_shift[DATA_W-1:0];
                opb    = FX_ONE - p_reg;
                div_hi = num_shift[PROD_W-1:DATA_W];
            end
            default:
            begin
                op_state = 1'b0;
            end
        endcase
        req.start = op_state && !issued_reg && !(state_reg == ST_GDIV && gdiv_sat);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        cur_frame_next = cur_frame_reg;
        slot_next      = slot_reg;
        succ_next      = succ_reg;
        coll_next      = coll_reg;
        empty_next     = empty_reg;
        iters_next     = iters_reg;
        limit_next     = limit_reg;
        e1_ok_next     = e1_ok_reg;
        ser_e1_next    = ser_e1_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        gamma_next     = gamma_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        term_next      = term_reg;
        e_next         = e_reg;
        e1_next        = e1_reg;
        p_next         = p_reg;
        tmp_next       = tmp_reg;
        next_size_next = next_size_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        acc_upd   = k_reg[0] ? (acc_reg - quot) : (acc_reg + quot);
        diff      = (tmp_reg > gamma_reg) ? (tmp_reg - gamma_reg) : (gamma_reg - tmp_reg);
        iters_inc = iters_reg + 1'b1;
        c_val     = fx_sat_add(int_mul_res(prod), FX_FRAC_MASK) >> FRACTION_BITS;
        p_val     = fx_mul_res(prod);

        if (req.start)
        begin
            issued_next = 1'b1;
        end
        if (arith_done)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_frame_next = frame_eff;
                    slot_next      = slot_inc;
                    succ_next      = succ_inc;
                    coll_next      = coll_inc;
                    empty_next     = empty_inc;
                    if (slot_inc >= frame_eff)
                    begin
                        gamma_next     = DATA_W'(init_gamma_reg);
                        iters_next     = '0;
                        limit_next     = 1'b0;
                        next_size_next = frame_eff;
                        state_next     = (coll_inc == '0) ? ST_DONE : ST_DMUL;
                    end
                end
            end
            ST_DMUL:
            begin
                // weighted tag count before division by the frame size
                if (arith_done)
                begin
                    x_next = fx_sat_add(int_mul_res(prod),
                                        DATA_W'(succ_reg) << FRACTION_BITS);
                    state_next = ST_XDIV;
                end
            end
            ST_XDIV:
            begin
                if (arith_done)
                begin
                    x_next = quot;
                    if ((quot >> (FRACTION_BITS + EXP_INT_W)) != '0)
                    begin
                        e_next     = '0;
                        state_next = ST_PMUL;
                    end
                    else
                    begin
                        acc_next    = FX_ONE;
                        term_next   = FX_ONE;
                        k_next      = K_W'(1);
                        ser_e1_next = !e1_ok_reg;
                        state_next  = ST_TMUL;
                    end
                end
            end
            ST_TMUL:
            begin
                if (arith_done)
                begin
                    term_next  = fx_mul_res(prod);
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                // accumulate one series term, alternating sign
                if (arith_done)
                begin
                    term_next = quot;
                    acc_next  = acc_upd;
                    if (k_reg == K_W'(SERIES_TERMS))
                    begin
                        if (ser_e1_reg)
                        begin
                            e1_next     = acc_upd;
                            e1_ok_next  = 1'b1;
                            ser_e1_next = 1'b0;
                            acc_next    = FX_ONE;
                            term_next   = FX_ONE;
                            k_next      = K_W'(1);
                            state_next  = ST_TMUL;
                        end
                        else
                        begin
                            e_next = acc_upd;
                            n_next = x_reg[FRACTION_BITS+EXP_INT_W-1:FRACTION_BITS];
                            state_next = (x_reg[FRACTION_BITS+EXP_INT_W-1:FRACTION_BITS] == '0)
                                         ? ST_PMUL : ST_EPOW;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_EPOW:
            begin
                if (arith_done)
                begin
                    e_next = fx_mul_res(prod);
                    n_next = n_reg - 1'b1;
                    if (n_reg == EXP_INT_W'(1))
                    begin
                        state_next = ST_PMUL;
                    end
                end
            end
            ST_PMUL:
            begin
                // degenerate denominator falls back to gamma of two
                if (arith_done)
                begin
                    if (p_val >= FX_ONE)
                    begin
                        tmp_next   = FX_TWO;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        p_next     = p_val;
                        state_next = ST_NMUL;
                    end
                end
            end
            ST_NMUL:
            begin
                if (arith_done)
                begin
                    tmp_next   = fx_mul_res(prod);
                    state_next = ST_GDIV;
                end
            end
            ST_GDIV:
            begin
                if (!issued_reg && gdiv_sat)
                begin
                    tmp_next   = FX_MAX;
                    state_next = ST_UPD;
                end
                else if (arith_done)
                begin
                    tmp_next   = quot;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // take the new gamma and test convergence
                gamma_next = tmp_reg;
                iters_next = iters_inc;
                if (diff <= DATA_W'(thresh_reg))
                begin
                    state_next = ST_CMUL;
                end
                else if (32'(iters_inc) >= MAX_ITERATIONS)
                begin
                    limit_next = 1'b1;
                    state_next = ST_CMUL;
                end
                else
                begin
                    state_next = ST_DMUL;
                end
            end
            ST_CMUL:
            begin
                if (arith_done)
                begin
                    next_size_next = clamp_frame(c_val);
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    cur_frame_next = next_size_reg;
                    slot_next      = '0;
                    succ_next      = '0;
                    coll_next      = '0;
                    empty_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_frame_reg <= INIT_FRAME_RESET;
            thresh_reg     <= THRESHOLD_RESET;
            init_gamma_reg <= INIT_GAMMA_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_INIT_FRAME: init_frame_reg <= cfg_data[FRAME_W-1:0];
                CFG_THRESHOLD:  thresh_reg     <= cfg_data[THRESH_W-1:0];
                CFG_INIT_GAMMA: init_gamma_reg <= cfg_data[GAMMA_W-1:0];
                default:        init_frame_reg <= init_frame_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            cur_frame_reg <= clamp_frame(DATA_W'(INIT_FRAME_RESET));
            slot_reg      <= '0;
            succ_reg      <= '0;
            coll_reg      <= '0;
            empty_reg     <= '0;
            iters_reg     <= '0;
            limit_reg     <= 1'b0;
            e1_ok_reg     <= 1'b0;
            ser_e1_reg    <= 1'b0;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            cur_frame_reg <= cur_frame_next;
            slot_reg      <= slot_next;
            succ_reg      <= succ_next;
            coll_reg      <= coll_next;
            empty_reg     <= empty_next;
            iters_reg     <= iters_next;
            limit_reg     <= limit_next;
            e1_ok_reg     <= e1_ok_next;
            ser_e1_reg    <= ser_e1_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        gamma_reg     <= gamma_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        term_reg      <= term_next;
        e_reg         <= e_next;
        e1_reg        <= e1_next;
        p_reg         <= p_next;
        tmp_reg       <= tmp_next;
        next_size_reg <= next_size_next;
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_next_reg  <= next_size_reg;
            o_succ_reg  <= succ_reg;
            o_coll_reg  <= coll_reg;
            o_empty_reg <= empty_reg;
            o_gamma_reg <= (gamma_reg[DATA_W-1:GAMMA_OUT_W] != '0) ? '1
                           : gamma_reg[GAMMA_OUT_W-1:0];
            o_iters_reg <= (32'(iters_reg) > 32'd31) ? ITER_OUT_W'(31)
                           : ITER_OUT_W'(iters_reg);
            o_limit_reg <= limit_reg;
            o_fin_reg   <= (coll_reg == '0);
        end
    end

    rfe_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .opa    (opa),
        .opb    (opb),
        .div_hi (div_hi),
        .done   (arith_done),
        .prod   (prod),
        .quot   (quot)
    );

    assign in_stall            = (state_reg != ST_IDLE);
    assign out_valid           = out_valid_reg;
    assign next_frame_size     = o_next_reg;
    assign success_slots       = o_succ_reg;
    assign collision_slots     = o_coll_reg;
    assign empty_slots         = o_empty_reg;
    assign gamma_estimate      = o_gamma_reg;
    assign iterations_used     = o_iters_reg;
    assign iteration_limit_hit = o_limit_reg;
    assign round_finished      = o_fin_reg;

`ifndef NO_ASSERTIONS
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        arith_done |-> issued_reg)
        else $error("arith done without an issued operation");

    a_slot_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (slot_reg < cur_frame_reg))
        else $error("slot index reached frame size while idle");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(iterations_used) <= MAX_ITERATIONS))
        else $error("iteration count above cap");

    a_finished_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && round_finished) |-> (iterations_used == '0 && !iteration_limit_hit))
        else $error("finished round reports iterations");
`endif

endmodule
